FILE: rtl/vop_pkg.sv
// Shared types, constants and helper functions for the oscillation probability block.
`default_nettype none
package vop_pkg;

  localparam int Q30_ONE_INT = 1 << 30;
  localparam logic [31:0] PHASE_K = 32'd868127901;
  localparam logic [31:0] THETA_K = 32'd683565276;

  // Pipeline depth of the squared-sine unit.
  localparam int SIN_LAT = 8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORIG  = 2'd1;
  localparam logic [1:0] ST_BAD_FINAL = 2'd2;
  localparam logic [1:0] ST_ZERO_E    = 2'd3;

  localparam logic [1:0] CFG_BASELINE = 2'd0;
  localparam logic [1:0] CFG_MASS     = 2'd1;
  localparam logic [1:0] CFG_ANGLE    = 2'd2;
  localparam logic [1:0] CFG_UE3      = 2'd3;

  // Pair codes select which probability a request returns.
  typedef enum logic [2:0] {
    PAIR_ME, PAIR_MM, PAIR_MT, PAIR_EE, PAIR_EM, PAIR_ET
  } pair_t;

  // Sideband that rides along the divider chain with each request.
  typedef struct packed {
    logic [1:0] status;
    pair_t      pair;
  } tag_t;

  // Signed Q30 multiply with truncation toward zero. Every operand of the sine
  // series stays below 2^31 in magnitude, so 32-bit magnitudes suffice.
  function automatic logic signed [33:0] smul30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] pr;
    logic [31:0] r;
    ua = a[33] ? 32'(-a) : 32'(a);
    ub = b[33] ? 32'(-b) : 32'(b);
    pr = 64'(ua) * 64'(ub);
    r = pr[61:30];
    smul30 = (a[33] ^ b[33]) ? -$signed(34'(r)) : $signed(34'(r));
  endfunction

  function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = 64'(a) * 64'(b);
    umul30 = pr[61:30];
  endfunction

  // Odd Taylor coefficients of the sine in Q30, highest order first.
  function automatic logic signed [33:0] sin_coef(input int k);
    case (k)
      0: sin_coef = -34'sd3864;
      1: sin_coef = 34'sd172272;
      2: sin_coef = -34'sd5026995;
      3: sin_coef = 34'sd85569306;
      4: sin_coef = -34'sd693598671;
      default: sin_coef = 34'sd1686629713;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vop_div_cell.sv
// One restoring-division cell: one quotient bit per stage.
`default_nettype none
module vop_div_cell
  import vop_pkg::*;
#(
  parameter int NW = 58,
  parameter int DW = 24,
  parameter int QB = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vin,
  input  wire logic [NW-1:0] nin,
  input  wire logic [NW-1:0] qin,
  input  wire logic [DW-1:0] din,
  input  wire tag_t          tin,
  input  wire logic          adv,
  output logic               vout,
  output logic [NW-1:0]      nout,
  output logic [NW-1:0]      qout,
  output logic [DW-1:0]      dout,
  output tag_t               tout
);
  logic [NW+DW-1:0] dsh;
  logic             fits;
  assign dsh  = (NW+DW)'(din) << QB;
  assign fits = (NW+DW)'(nin) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
    if (adv) begin
      nout <= fits ? NW'((NW+DW)'(nin) - dsh) : nin;
      qout <= qin | (fits ? (NW'(1) << QB) : NW'(0));
      dout <= din;
      tout <= tin;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/vop_tail.sv
// Back end: phase scaling, a pipelined squared sine and probability selection, then an output register.
`default_nettype none
module vop_sine
  import vop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] ph,
  output logic [31:0]      sq
);
  logic [31:0]        t;
  logic signed [33:0] zt;
  logic signed [33:0] z [6];
  logic signed [33:0] z2 [6];
  logic signed [33:0] acc [6];
  logic signed [33:0] s_c;
  logic [31:0]        s_r;

  // Fold the phase into the first quarter turn; only the squared sine is needed.
  always_comb begin
    t = ph & 32'h7FFF_FFFF;
    if (t > 32'h4000_0000) t = 32'h8000_0000 - t;
    zt = $signed(34'(t));
  end

  always_comb begin
    s_c = smul30(z[5], acc[5]);
    if (s_c < 0) s_c = '0;
    if (s_c > 34'sd1073741824) s_c = 34'sd1073741824;
  end

  // One multiply per stage: square, five Horner steps, the final odd factor, the square.
  always_ff @(posedge clk) begin
    if (en) begin
      z[0] <= zt;
      z2[0] <= smul30(zt, zt);
      acc[0] <= sin_coef(0);
      for (int k = 1; k < 6; k++) begin
        z[k] <= z[k-1];
        z2[k] <= z2[k-1];
        acc[k] <= sin_coef(k) + smul30(z2[k-1], acc[k-1]);
      end
      s_r <= s_c[31:0];
      sq <= umul30(s_r, s_r);
    end
  end
endmodule

module vop_tail
  import vop_pkg::*;
#(
  parameter int NW = 58,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vin,
  input  wire logic [NW-1:0] q,
  input  wire tag_t          tin,
  input  wire logic [31:0]   pmt_base,
  input  wire logic [31:0]   pme_base,
  input  wire logic [31:0]   pet_base,
  input  wire logic          adv,
  output logic               valid,
  output logic [PROB_FRAC_BITS:0] probability,
  output logic [1:0]         status
);
  localparam int SH = 30 - PROB_FRAC_BITS;

  logic [31:0] phase_r;
  logic [31:0] s2;
  tag_t        tag_d [SIN_LAT+1];
  logic        v_d [SIN_LAT+1];
  logic [63:0] qq;
  logic [63:0] low56;
  logic [31:0] pmt, pme, pet, res;
  logic [32:0] psum;
  logic [31:0] rnd;
  logic [31:0] outv;

  vop_sine u_sine (.clk(clk), .en(adv), .ph(phase_r), .sq(s2));

  always_comb begin
    qq = 64'(q);
    low56 = (((64'(PHASE_K) * 64'(qq[63:32])) & 64'hFF_FFFF) << 32)
            + 64'(PHASE_K) * 64'(qq[31:0]);
  end

  always_comb begin
    pmt = umul30(pmt_base, s2);
    pme = umul30(pme_base, s2);
    pet = umul30(pet_base, s2);
    psum = 33'(pmt) + 33'(pme);
    res = 32'd0;
    case (tag_d[SIN_LAT].pair)
      PAIR_ME, PAIR_EM: res = pme;
      PAIR_MT: res = pmt;
      PAIR_ET: res = pet;
      PAIR_MM: res = (psum >= 33'(Q30_ONE_INT)) ? 32'd0 : 32'(33'(Q30_ONE_INT) - psum);
      PAIR_EE: begin
        psum = 33'(pet) + 33'(pme);
        res = (psum >= 33'(Q30_ONE_INT)) ? 32'd0 : 32'(33'(Q30_ONE_INT) - psum);
      end
      default: res = 32'd0;
    endcase
    if (SH > 0) rnd = (res + (32'd1 << (SH - 1))) >> SH;
    else rnd = res;
    outv = (rnd > (32'd1 << PROB_FRAC_BITS)) ? (32'd1 << PROB_FRAC_BITS) : rnd;
    if (tag_d[SIN_LAT].status != ST_OK) outv = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SIN_LAT; k++) v_d[k] <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v_d[0] <= vin;
      for (int k = 1; k <= SIN_LAT; k++) v_d[k] <= v_d[k-1];
      valid <= v_d[SIN_LAT];
    end
    if (adv) begin
      phase_r <= low56[55:24];
      tag_d[0] <= tin;
      for (int k = 1; k <= SIN_LAT; k++) tag_d[k] <= tag_d[k-1];
      probability <= outv[PROB_FRAC_BITS:0];
      status <= tag_d[SIN_LAT].status;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/vacuum_oscillation_probability.sv
// Top level of the vacuum three-flavor oscillation probability block.
// Requests arrive on in_valid/in_stall with final_flavor, orig_flavor and energy;
// results leave on out_valid/out_stall with probability (Q1.16) and status.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data and
// are taken in any cycle; they must only be issued while the block is idle.
// The angle terms follow the registers through registered sine units, which settle
// long before a request sent after a write reaches the back end. The phase
// quotient comes from a chain of division cells, one quotient bit per cell. With
// the default energy format a request passes 50 division cells, a phase register,
// eight sine stages and the output register. One request enters every cycle
// while in_stall is low; throughput is one result per cycle.
// The whole pipeline advances together: while out_stall holds a valid
// result, nothing moves and in_stall is raised, so no result is lost.
// Reset clears all valid flags and loads the register reset values.
`default_nettype none
module vacuum_oscillation_probability
  import vop_pkg::*;
#(
  parameter int PROB_FRAC_BITS = 16,
  parameter int ENERGY_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [5:0]  final_flavor,
  input  wire logic signed [5:0]  orig_flavor,
  input  wire logic [23:0]        energy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PROB_FRAC_BITS:0] probability,
  output logic [1:0]              status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);
  localparam int NW = 34 + ENERGY_FRAC_BITS;

  logic [13:0] baseline_km;
  logic [19:0] mass_split;
  logic [17:0] mixing_angle;
  logic [16:0] ue3_squared;
  logic adv;
  logic [5:0] fa, oa;
  tag_t tag_in;
  logic [31:0] pmt_base, pme_base, pet_base;
  logic [63:0] tp;
  logic [31:0] u30_c;
  logic [31:0] tph_r, u30_r, om_r, fu_r, omsq_r;
  logic [31:0] sth, cth, s2th;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_km <= 14'd735;
      mass_split <= 20'd40265;
      mixing_angle <= 18'd51472;
      ue3_squared <= 17'd1966;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASELINE: baseline_km <= cfg_data[13:0];
        CFG_MASS: mass_split <= cfg_data;
        CFG_ANGLE: mixing_angle <= cfg_data[17:0];
        CFG_UE3: ue3_squared <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Angle terms depend only on configuration; they run freely behind the registers.
  assign tp = 64'(mixing_angle) * 64'(THETA_K);
  assign u30_c = 32'((ue3_squared > 17'd65536) ? 17'd65536 : ue3_squared) << 14;

  vop_sine u_sth (.clk(clk), .en(1'b1), .ph(tph_r), .sq(sth));
  vop_sine u_cth (.clk(clk), .en(1'b1), .ph(tph_r + 32'h4000_0000), .sq(cth));
  vop_sine u_s2th (.clk(clk), .en(1'b1), .ph(tph_r << 1), .sq(s2th));

  always_ff @(posedge clk) begin
    tph_r <= tp[47:16];
    u30_r <= u30_c;
    om_r <= 32'(Q30_ONE_INT) - u30_c;
    fu_r <= umul30(u30_r, om_r) << 2;
    omsq_r <= umul30(om_r, om_r);
    pmt_base <= umul30(omsq_r, s2th);
    pme_base <= umul30(sth, fu_r);
    pet_base <= umul30(fu_r, cth);
  end

  always_comb begin
    fa = final_flavor[5] ? 6'(-final_flavor) : final_flavor;
    oa = orig_flavor[5] ? 6'(-orig_flavor) : orig_flavor;
    tag_in.status = ST_OK;
    tag_in.pair = PAIR_MM;
    if (oa != 6'd12 && oa != 6'd14) tag_in.status = ST_BAD_ORIG;
    else if (fa != 6'd12 && fa != 6'd14 && fa != 6'd16) tag_in.status = ST_BAD_FINAL;
    else if (energy == 24'd0) tag_in.status = ST_ZERO_E;
    if (oa == 6'd14) begin
      tag_in.pair = (fa == 6'd12) ? PAIR_ME : (fa == 6'd16) ? PAIR_MT : PAIR_MM;
    end else begin
      tag_in.pair = (fa == 6'd14) ? PAIR_EM : (fa == 6'd16) ? PAIR_ET : PAIR_EE;
    end
  end

  logic          v [NW+1];
  logic [NW-1:0] n [NW+1];
  logic [NW-1:0] qv [NW+1];
  logic [23:0]   d [NW+1];
  tag_t          t [NW+1];

  assign v[0] = in_valid;
  assign n[0] = NW'(34'(mass_split) * 34'(baseline_km)) << ENERGY_FRAC_BITS;
  assign qv[0] = '0;
  assign d[0] = (energy == 24'd0) ? 24'd1 : energy;
  assign t[0] = tag_in;

  for (genvar g = 0; g < NW; g++) begin : g_div
    vop_div_cell #(.NW(NW), .DW(24), .QB(NW - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .vin(v[g]), .nin(n[g]), .qin(qv[g]), .din(d[g]),
      .tin(t[g]), .adv(adv), .vout(v[g+1]), .nout(n[g+1]), .qout(qv[g+1]),
      .dout(d[g+1]), .tout(t[g+1])
    );
  end

  vop_tail #(.NW(NW), .PROB_FRAC_BITS(PROB_FRAC_BITS)) u_tail (
    .clk(clk), .rst(rst), .vin(v[NW]), .q(qv[NW]), .tin(t[NW]),
    .pmt_base(pmt_base), .pme_base(pme_base), .pet_base(pet_base), .adv(adv),
    .valid(out_valid), .probability(probability), .status(status)
  );

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("input taken during output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (probability == '0)) else $error("flagged nonzero");
`endif
endmodule
`default_nettype wire
